// ===== rtl/mssb_pkg.sv =====
`default_nettype none
package mssb_pkg;

  localparam int MAX_BLOCK = 64;
  localparam int AW        = $clog2(MAX_BLOCK);
  localparam int CW        = AW + 1;

  localparam int VAL_W     = 32;
  localparam int LEN_W     = 7;

  // input op codes
  localparam logic [1:0] OP_LOAD_OWN  = 2'd0;
  localparam logic [1:0] OP_LOAD_PART = 2'd1;
  localparam logic [1:0] OP_MERGE     = 2'd2;

  // configuration register indexes
  localparam logic REG_BLOCK_LEN = 1'b0;
  localparam logic REG_KEEP_HIGH = 1'b1;

  typedef struct packed {
    logic [1:0]              op;
    logic [5:0]              index;
    logic signed [VAL_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [5:0]              index_res;
    logic signed [VAL_W-1:0] value_res;
    logic                    last;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load_own;
    logic load_part;
    logic init;
    logic step;
    logic drain;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic n_zero;
    logic merge_last;
    logic drain_all;
  } status_t;

endpackage
`default_nettype wire

// ===== rtl/merge_split_sorted_blocks_core.sv =====
// Merge-split step of odd-even transposition sort on two sorted blocks.
// Loads are op 0/1 and merges op 2; an item is accepted every cycle while idle.
// A merge of n = min(block_len, 64) elements holds in_stall through a head read, n merge
// steps, n reads out and a final copy back; output stalls lengthen the reads out.
// Results leave one per cycle while out_stall is low.
// Reset sets block_len to 64, keep_high to 0 and clears control; stores keep content.
`default_nettype none
module merge_split_sorted_blocks_core (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire mssb_pkg::in_item_t          in_data,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output mssb_pkg::out_item_t              out_data,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic                        cfg_index,
  input  wire logic [mssb_pkg::LEN_W-1:0]  cfg_data
);

  mssb_pkg::cmd_t    cmd;
  mssb_pkg::status_t status;
  logic              cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  mssb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_data.op),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  mssb_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// ===== rtl/mssb_ctrl.sv =====
`default_nettype none
module mssb_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire logic [1:0]       in_op,
  output logic                  in_stall,
  input  wire mssb_pkg::status_t status,
  output mssb_pkg::cmd_t        cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_PRIME = 2'd1;
  localparam logic [1:0] ST_MERGE = 2'd2;
  localparam logic [1:0] ST_DRAIN = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       accept;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && (state_r == ST_IDLE);

  always_comb begin
    cmd           = '0;
    cmd.load_own  = accept && (in_op == mssb_pkg::OP_LOAD_OWN);
    cmd.load_part = accept && (in_op == mssb_pkg::OP_LOAD_PART);
    cmd.init      = accept && (in_op == mssb_pkg::OP_MERGE);
    cmd.step      = (state_r == ST_MERGE);
    cmd.drain     = (state_r == ST_DRAIN);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && (in_op == mssb_pkg::OP_MERGE) && !status.n_zero) begin
          state_nxt = ST_PRIME;
        end
      end
      // first heads of both blocks are read here
      ST_PRIME: begin
        state_nxt = ST_MERGE;
      end
      ST_MERGE: begin
        if (status.merge_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (status.drain_all) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/mssb_dp.sv =====
`default_nettype none
module mssb_dp (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_valid,
  input  wire logic                        cfg_index,
  input  wire logic [mssb_pkg::LEN_W-1:0]  cfg_data,
  input  wire mssb_pkg::in_item_t          in_data,
  input  wire mssb_pkg::cmd_t              cmd,
  output mssb_pkg::status_t                status,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output mssb_pkg::out_item_t              out_data
);

  localparam int AW = mssb_pkg::AW;
  localparam int CW = mssb_pkg::CW;
  localparam int VW = mssb_pkg::VAL_W;

  logic [mssb_pkg::LEN_W-1:0] block_len_r;
  logic                       keep_high_r;

  logic [VW-1:0] own_mem  [mssb_pkg::MAX_BLOCK];
  logic [VW-1:0] part_mem [mssb_pkg::MAX_BLOCK];
  logic [VW-1:0] mrg_mem  [mssb_pkg::MAX_BLOCK];

  logic [VW-1:0] own_q_r;
  logic [VW-1:0] part_q_r;

  logic [CW-1:0] a_r, b_r, c_r, k_r;
  logic [CW-1:0] a_nxt, b_nxt;
  logic [CW-1:0] n;
  logic [CW-1:0] own_ra_full, part_ra_full, mrg_wa_full;

  logic          take_own;
  logic          idx_ok;
  logic          own_we;
  logic [AW-1:0] own_wa;
  logic [VW-1:0] own_wd;
  logic          rd_en;
  logic          out_valid_r;
  logic          wb_r;
  logic [AW-1:0] idx_res_r;
  logic [VW-1:0] value_res_r;
  logic          last_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_len_r <= mssb_pkg::LEN_W'(mssb_pkg::MAX_BLOCK);
      keep_high_r <= 1'b0;
    end else if (cfg_valid) begin
      if (cfg_index == mssb_pkg::REG_BLOCK_LEN) begin
        block_len_r <= cfg_data;
      end else begin
        keep_high_r <= cfg_data[0];
      end
    end
  end

  assign n = (CW'(block_len_r) > CW'(mssb_pkg::MAX_BLOCK)) ?
             CW'(mssb_pkg::MAX_BLOCK) : CW'(block_len_r);

  // low mode: ties go to own; high mode: ties go to own from the top
  assign take_own = keep_high_r ? ($signed(part_q_r) <= $signed(own_q_r))
                                : ($signed(own_q_r) <= $signed(part_q_r));

  assign a_nxt = a_r + CW'(cmd.step && take_own);
  assign b_nxt = b_r + CW'(cmd.step && !take_own);

  // read the next head each cycle; an unchanged count rereads the same entry
  assign own_ra_full  = keep_high_r ? (n - 1'b1 - a_nxt) : a_nxt;
  assign part_ra_full = keep_high_r ? (n - 1'b1 - b_nxt) : b_nxt;
  assign mrg_wa_full  = keep_high_r ? (n - 1'b1 - c_r) : c_r;

  always_ff @(posedge clk) begin
    own_q_r  <= own_mem[own_ra_full[AW-1:0]];
    part_q_r <= part_mem[part_ra_full[AW-1:0]];
  end

  // own store: loads while idle, merged values copied back during drain
  assign idx_ok = ({1'b0, in_data.index} < CW'(mssb_pkg::MAX_BLOCK));
  assign own_we = (cmd.load_own && idx_ok) || wb_r;
  assign own_wa = wb_r ? idx_res_r : in_data.index[AW-1:0];
  assign own_wd = wb_r ? value_res_r : in_data.value;

  always_ff @(posedge clk) begin
    if (own_we) begin
      own_mem[own_wa] <= own_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_part && idx_ok) begin
      part_mem[in_data.index[AW-1:0]] <= in_data.value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      mrg_mem[mrg_wa_full[AW-1:0]] <= take_own ? own_q_r : part_q_r;
    end
  end

  // counters
  always_ff @(posedge clk) begin
    if (cmd.init) begin
      a_r <= '0;
      b_r <= '0;
      c_r <= '0;
      k_r <= '0;
    end else begin
      if (cmd.step) begin
        a_r <= a_nxt;
        b_r <= b_nxt;
        c_r <= c_r + 1'b1;
      end
      if (rd_en) begin
        k_r <= k_r + 1'b1;
      end
    end
  end

  // the merged store's read register is the output register
  assign rd_en = cmd.drain && (k_r != n) && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (rd_en) begin
      value_res_r <= mrg_mem[k_r[AW-1:0]];
      idx_res_r   <= k_r[AW-1:0];
      last_r      <= (k_r == n - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      wb_r        <= 1'b0;
    end else begin
      if (!out_valid_r || !out_stall) begin
        out_valid_r <= rd_en;
      end
      wb_r <= rd_en;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_data.index_res = 6'(idx_res_r);
  assign out_data.value_res = value_res_r;
  assign out_data.last      = last_r;

  assign status.n_zero     = (n == '0);
  assign status.merge_last = (c_r == n - 1'b1);
  assign status.drain_all  = (k_r == n);

endmodule
`default_nettype wire

// ===== tb/merge_split_sorted_blocks_checker.sv =====
`timescale 1ns / 100ps
module merge_split_sorted_blocks_checker
  import mssb_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire logic             in_stall,
  input  wire in_item_t         in_data,
  input  wire logic             out_valid,
  input  wire logic             out_stall,
  input  wire out_item_t        out_data,
  input  wire logic             cfg_valid,
  input  wire logic             cfg_ready,
  input  wire logic             cfg_index,
  input  wire logic [LEN_W-1:0] cfg_data,
  output int                    errors,
  output int                    pending
);

  logic signed [VAL_W-1:0] own_mem  [MAX_BLOCK];
  logic signed [VAL_W-1:0] part_mem [MAX_BLOCK];
  logic [LEN_W-1:0]        len_reg  = LEN_W'(MAX_BLOCK);
  logic                    high_reg = 1'b0;
  out_item_t               merged_q [$];
  int                      fail_count = 0;
  int                      merge_pending = 0;

  assign errors  = fail_count;
  assign pending = merge_pending;

  task automatic report_error(input string msg);
    fail_count++;
    $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  // Forward merge keeps the smallest, backward merge the largest; ties go to own.
  task automatic predict_merge();
    int n, a, b, c;
    logic signed [VAL_W-1:0] merged [MAX_BLOCK];
    out_item_t r;
    n = (len_reg > MAX_BLOCK) ? MAX_BLOCK : int'(len_reg);
    a = 0;
    b = 0;
    for (c = 0; c < n; c++) begin
      if (!high_reg) begin
        if (part_mem[b] < own_mem[a]) begin
          merged[c] = part_mem[b];
          b++;
        end else begin
          merged[c] = own_mem[a];
          a++;
        end
      end else begin
        if (part_mem[n-1-b] <= own_mem[n-1-a]) begin
          merged[n-1-c] = own_mem[n-1-a];
          a++;
        end else begin
          merged[n-1-c] = part_mem[n-1-b];
          b++;
        end
      end
    end
    for (c = 0; c < n; c++) begin
      own_mem[c]  = merged[c];
      r.index_res = 6'(c);
      r.value_res = merged[c];
      r.last      = (c == n - 1);
      merged_q.push_back(r);
    end
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (merged_q.size() == 0) begin
      report_error($sformatf("unexpected result index %0d value %0d last %0b",
                             got.index_res, got.value_res, got.last));
    end else begin
      want = merged_q.pop_front();
      if (got.index_res !== want.index_res)
        report_error($sformatf("index_res got %0d want %0d",
                               got.index_res, want.index_res));
      if (got.value_res !== want.value_res)
        report_error($sformatf("value_res at %0d got %0d want %0d",
                               want.index_res, got.value_res, want.value_res));
      if (got.last !== want.last)
        report_error($sformatf("last at %0d got %0b want %0b",
                               want.index_res, got.last, want.last));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      len_reg  = LEN_W'(MAX_BLOCK);
      high_reg = 1'b0;
      merged_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_BLOCK_LEN)
          len_reg = cfg_data;
        else
          high_reg = cfg_data[0];
      end
      if (out_valid && !out_stall)
        check_result(out_data);
      if (in_valid && !in_stall) begin
        case (in_data.op)
          OP_LOAD_OWN:  own_mem[in_data.index]  = in_data.value;
          OP_LOAD_PART: part_mem[in_data.index] = in_data.value;
          OP_MERGE:     predict_merge();
          default: ;
        endcase
      end
    end
    merge_pending <= merged_q.size();
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
module testbench;
  import mssb_pkg::*;

  localparam logic [1:0] OP_UNUSED    = 2'd3;
  localparam int         ITEM_TARGET  = 350;
  localparam int         DRAIN_CYCLES = 8;
  localparam int         CYCLE_LIMIT  = 10000000;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  in_item_t         in_data   = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_item_t        out_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic             cfg_index = 1'b0;
  logic [LEN_W-1:0] cfg_data  = '0;
  int               errors;
  int               pending;

  int               cycle_count = 0;
  int               stall_left  = 0;
  int               items_sent  = 0;
  bit               sender_idles    = 1'b1;
  bit               receiver_stalls = 1'b1;
  logic [LEN_W-1:0] cur_len  = LEN_W'(MAX_BLOCK);
  logic             cur_high = 1'b0;
  bit               own_loaded  [MAX_BLOCK];
  bit               part_loaded [MAX_BLOCK];
  int               own_vals    [MAX_BLOCK];
  int               part_vals   [MAX_BLOCK];

  merge_split_sorted_blocks_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  merge_split_sorted_blocks_checker chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** merge_split_sorted_blocks_core: FAILED **");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else begin
      out_stall  <= receiver_stalls && ($urandom_range(0, 2) == 0);
      stall_left <= pick_gap();
    end
  end

  function automatic in_item_t make_item(input logic [1:0] op, input int idx, input int val);
    in_item_t it;
    it.op    = op;
    it.index = 6'(idx);
    it.value = val;
    return it;
  endfunction

  function automatic int eff_len();
    return (cur_len > MAX_BLOCK) ? MAX_BLOCK : int'(cur_len);
  endfunction

  // every entry a merge would read must have been loaded since reset
  function automatic bit merge_safe();
    int n;
    n = eff_len();
    for (int k = 0; k < n; k++)
      if (!own_loaded[k] || !part_loaded[k]) return 1'b0;
    return 1'b1;
  endfunction

  // valid stays up between back-to-back items; it only drops for a gap
  task automatic send_item(input in_item_t it);
    int gap;
    gap = sender_idles ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (it.op == OP_LOAD_OWN) own_loaded[it.index] = 1'b1;
    if (it.op == OP_LOAD_PART) part_loaded[it.index] = 1'b1;
    if (it.op != OP_UNUSED) items_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input logic [LEN_W-1:0] len, input logic high);
    cfg_valid <= 1'b1;
    cfg_index <= REG_BLOCK_LEN;
    cfg_data  <= len;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    // only bit 0 of keep_high counts, so junk goes in the upper bits
    cfg_index <= REG_KEEP_HIGH;
    cfg_data  <= {6'($urandom), high};
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cur_len  = len;
    cur_high = high;
  endtask

  task automatic fill_sorted(input int n, input bit narrow, output int vals [MAX_BLOCK]);
    int key, j;
    for (int k = 0; k < MAX_BLOCK; k++) vals[k] = 0;
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(0, 15))
        0:       key = 32'h8000_0000;
        1:       key = 32'h7fff_ffff;
        default: key = narrow ? $urandom_range(0, 6) - 3 : $urandom;
      endcase
      j = k;
      while (j > 0 && vals[j-1] > key) begin
        vals[j] = vals[j-1];
        j--;
      end
      vals[j] = key;
    end
  endtask

  task automatic load_block(input logic [1:0] op, input int n, input int vals [MAX_BLOCK],
                            input bit descending);
    int idx;
    for (int k = 0; k < n; k++) begin
      idx = descending ? n - 1 - k : k;
      send_item(make_item(op, idx, vals[idx]));
    end
  endtask

  initial begin
    int n, r;
    bit fresh, partner_first, descending, big_done;
    logic [LEN_W-1:0] new_len;
    in_item_t it;

    big_done = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // single element: partner wins low mode, then a tie goes to own
    configure(7'd1, 1'b0);
    send_item(make_item(OP_LOAD_OWN, 0, 32'h7fff_ffff));
    send_item(make_item(OP_LOAD_PART, 0, 32'h8000_0000));
    send_item(make_item(OP_MERGE, 0, 0));
    send_item(make_item(OP_UNUSED, 63, 32'hffff_ffff));
    send_item(make_item(OP_MERGE, 63, 32'hffff_ffff));
    wait_drained();

    configure(7'd1, 1'b1);
    send_item(make_item(OP_LOAD_OWN, 0, -1));
    send_item(make_item(OP_MERGE, 0, 0));
    wait_drained();

    // zero length: merge yields nothing
    configure(7'd0, 1'b1);
    send_item(make_item(OP_MERGE, 0, 0));
    wait_drained();

    // ties across blocks and an unsorted partner, both modes
    configure(7'd4, 1'b0);
    send_item(make_item(OP_LOAD_OWN, 63, 0));
    send_item(make_item(OP_LOAD_OWN, 0, -5));
    send_item(make_item(OP_LOAD_OWN, 1, 0));
    send_item(make_item(OP_LOAD_OWN, 2, 7));
    send_item(make_item(OP_LOAD_OWN, 3, 9));
    send_item(make_item(OP_LOAD_PART, 0, 0));
    send_item(make_item(OP_LOAD_PART, 1, 12));
    send_item(make_item(OP_LOAD_PART, 2, -2));
    send_item(make_item(OP_LOAD_PART, 3, 1));
    send_item(make_item(OP_MERGE, 0, 0));
    wait_drained();
    configure(7'd4, 1'b1);
    send_item(make_item(OP_MERGE, 0, 0));
    wait_drained();

    while (items_sent < ITEM_TARGET) begin
      sender_idles    = ($urandom_range(0, 3) != 0);
      receiver_stalls = ($urandom_range(0, 3) != 0);
      r = $urandom_range(0, 99);
      if (!big_done && items_sent > 120) begin
        // full store, then a length past the store size
        big_done = 1'b1;
        fill_sorted(MAX_BLOCK, 1'b0, own_vals);
        fill_sorted(MAX_BLOCK, 1'b0, part_vals);
        configure(LEN_W'(MAX_BLOCK), 1'($urandom_range(0, 1)));
        load_block(OP_LOAD_OWN, MAX_BLOCK, own_vals, 1'b0);
        load_block(OP_LOAD_PART, MAX_BLOCK, part_vals, 1'b1);
        send_item(make_item(OP_MERGE, 0, $urandom));
        wait_drained();
        configure(7'd127, !cur_high);
        send_item(make_item(OP_MERGE, 0, $urandom));
      end else if (r < 82) begin
        if ($urandom_range(0, 2) != 0) begin
          r = $urandom_range(0, 19);
          if (r == 0) new_len = 7'd0;
          else if (r < 16) new_len = 7'($urandom_range(1, 8));
          else new_len = 7'($urandom_range(9, 20));
          configure(new_len, 1'($urandom_range(0, 1)));
        end
        n = eff_len();
        fresh = !merge_safe() || ($urandom_range(0, 3) != 0);
        partner_first = 1'($urandom_range(0, 1));
        descending = 1'($urandom_range(0, 1));
        fill_sorted(n, 1'($urandom_range(0, 1)), own_vals);
        fill_sorted(n, 1'($urandom_range(0, 1)), part_vals);
        if (fresh && !partner_first) load_block(OP_LOAD_OWN, n, own_vals, descending);
        load_block(OP_LOAD_PART, n, part_vals, descending);
        if (fresh && partner_first) load_block(OP_LOAD_OWN, n, own_vals, !descending);
        send_item(make_item(OP_MERGE, $urandom_range(0, 63), $urandom));
        if ($urandom_range(0, 3) == 0)
          send_item(make_item(OP_MERGE, $urandom_range(0, 63), $urandom));
      end else begin
        // stray ops and unsorted loads
        repeat ($urandom_range(6, 14)) begin
          it.op    = 2'($urandom_range(0, 3));
          it.index = 6'($urandom);
          it.value = $urandom;
          if (it.op == OP_MERGE && !merge_safe()) it.op = OP_LOAD_PART;
          send_item(it);
        end
      end
      wait_drained();
    end

    if (errors == 0 && pending == 0)
      $display("** merge_split_sorted_blocks_core: PASSED **");
    else
      $display("** merge_split_sorted_blocks_core: FAILED **");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/mssb_pkg.sv
rtl/mssb_ctrl.sv
rtl/mssb_dp.sv
rtl/merge_split_sorted_blocks_core.sv
tb/merge_split_sorted_blocks_checker.sv
tb/testbench.sv
